@@ rtl/sdspi_pkg.sv @@
// Package: codes, types and CSD decode for the SD card SPI host engine.
package sdspi_pkg;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned CsdBytes    = 16;

  localparam logic [1:0] ActInit = 2'd0;
  localparam logic [1:0] ActRead = 2'd1;
  localparam logic [1:0] ActCap  = 2'd2;
  localparam logic [1:0] ActByte = 2'd3;

  localparam logic [3:0] PhIdle  = 4'd0;
  localparam logic [3:0] PhDummy = 4'd1;
  localparam logic [3:0] PhLead  = 4'd2;
  localparam logic [3:0] PhFrame = 4'd3;
  localparam logic [3:0] PhPoll  = 4'd4;
  localparam logic [3:0] PhOcr   = 4'd5;
  localparam logic [3:0] PhTail  = 4'd6;
  localparam logic [3:0] PhToken = 4'd7;
  localparam logic [3:0] PhData  = 4'd8;
  localparam logic [3:0] PhCrc   = 4'd9;
  localparam logic [3:0] PhStall = 4'd10;

  localparam logic [3:0] StClk10 = 4'd0;
  localparam logic [3:0] StCmd0  = 4'd1;
  localparam logic [3:0] StClk2  = 4'd2;
  localparam logic [3:0] StCmd8  = 4'd3;
  localparam logic [3:0] StCmd55 = 4'd4;
  localparam logic [3:0] StCmd41 = 4'd5;
  localparam logic [3:0] StCmd58 = 4'd6;
  localparam logic [3:0] StCmd59 = 4'd7;
  localparam logic [3:0] StCmd16 = 4'd8;
  localparam logic [3:0] StCmd17 = 4'd9;
  localparam logic [3:0] StCmd9  = 4'd10;

  localparam logic [5:0] Cmd0  = 6'd0;
  localparam logic [5:0] Cmd8  = 6'd8;
  localparam logic [5:0] Cmd9  = 6'd9;
  localparam logic [5:0] Cmd16 = 6'd16;
  localparam logic [5:0] Cmd17 = 6'd17;
  localparam logic [5:0] Cmd41 = 6'd41;
  localparam logic [5:0] Cmd55 = 6'd55;
  localparam logic [5:0] Cmd58 = 6'd58;
  localparam logic [5:0] Cmd59 = 6'd59;

  localparam logic [1:0] TypeUnknown = 2'd0;
  localparam logic [1:0] TypeV1      = 2'd1;
  localparam logic [1:0] TypeHc      = 2'd2;
  localparam logic [1:0] TypeStd2    = 2'd3;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatTimeout = 2'd1;
  localparam logic [1:0] StatReject  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] sector;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        chip_select;
    logic        fast_clock;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        data_last;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  response;
    logic [1:0]  card_type;
    logic [31:0] capacity;
  } out_item_t;

  // (device size + 1) << (size multiplier + 2 + block length exponent), kept to 32 bits
  function automatic logic [31:0] csd_cap(logic [11:0] csize, logic [2:0] mult,
                                          logic [3:0] bl);
    logic [4:0] sh;
    logic [12:0] base;
    sh   = 5'(mult) + 5'd2 + 5'(bl);
    base = 13'(csize) + 13'd1;
    return 32'(base) << sh;
  endfunction

endpackage

@@ rtl/sdspi_core.sv @@
// Sequencer: one item in, next state and one result out, combinational.
module sdspi_core (
  input  sdspi_pkg::in_item_t  item_i,
  input  logic [3:0]           phase_i,
  input  logic [1:0]           op_i,
  input  logic [5:0]           cmd_i,
  input  logic [31:0]          arg_i,
  input  logic [9:0]           bcnt_i,
  input  logic [16:0]          pcnt_i,
  input  logic [7:0]           att_i,
  input  logic                 hc_i,
  input  logic                 v2_i,
  input  logic [1:0]           type_i,
  input  logic                 speed_i,
  input  logic [3:0]           seq_i,
  input  logic [7:0]           resp_i,
  input  logic [11:0]          csize_i,
  input  logic [2:0]           mult_i,
  input  logic [3:0]           bl_i,
  output logic [3:0]           phase_o,
  output logic [1:0]           op_o,
  output logic [5:0]           cmd_o,
  output logic [31:0]          arg_o,
  output logic [9:0]           bcnt_o,
  output logic [16:0]          pcnt_o,
  output logic [7:0]           att_o,
  output logic                 hc_o,
  output logic                 v2_o,
  output logic [1:0]           type_o,
  output logic                 speed_o,
  output logic [3:0]           seq_o,
  output logic [7:0]           resp_o,
  output logic                 csd_we_o,
  output logic [3:0]           csd_addr_o,
  output sdspi_pkg::out_item_t res_o
);

  logic [7:0] rx;
  logic [7:0] att_inc;
  logic [9:0] bcnt_inc;
  logic [16:0] pcnt_inc;
  logic [7:0] fbyte;

  always_comb begin
    rx       = item_i.rx_byte;
    att_inc  = att_i + 8'd1;
    bcnt_inc = bcnt_i + 10'd1;
    pcnt_inc = pcnt_i + 17'd1;
    case (bcnt_i[2:0])
      3'd0:    fbyte = {2'b01, cmd_i};
      3'd1:    fbyte = arg_i[31:24];
      3'd2:    fbyte = arg_i[23:16];
      3'd3:    fbyte = arg_i[15:8];
      3'd4:    fbyte = arg_i[7:0];
      default: fbyte = (cmd_i == sdspi_pkg::Cmd8) ? 8'h87 : 8'h95;
    endcase
  end

  always_comb begin
    phase_o = phase_i; op_o = op_i; cmd_o = cmd_i; arg_o = arg_i;
    bcnt_o = bcnt_i; pcnt_o = pcnt_i; att_o = att_i; hc_o = hc_i; v2_o = v2_i;
    type_o = type_i; speed_o = speed_i; seq_o = seq_i; resp_o = resp_i;
    csd_we_o = 1'b0; csd_addr_o = bcnt_i[3:0];
    res_o = '0;

    if (item_i.action == sdspi_pkg::ActInit) begin
      op_o = sdspi_pkg::ActInit; speed_o = 1'b0; att_o = '0;
      bcnt_o = 10'd10; seq_o = sdspi_pkg::StClk10; phase_o = sdspi_pkg::PhDummy;
      res_o.tx_byte = 8'hFF; res_o.tx_valid = 1'b1;
    end else if (item_i.action == sdspi_pkg::ActRead) begin
      op_o = sdspi_pkg::ActRead; cmd_o = sdspi_pkg::Cmd17;
      arg_o = hc_i ? item_i.sector : {item_i.sector[22:0], 9'd0};
      seq_o = sdspi_pkg::StCmd17; phase_o = sdspi_pkg::PhLead;
      res_o.tx_byte = 8'hFF; res_o.tx_valid = 1'b1;
    end else if (item_i.action == sdspi_pkg::ActCap) begin
      op_o = sdspi_pkg::ActCap; cmd_o = sdspi_pkg::Cmd9; arg_o = '0;
      seq_o = sdspi_pkg::StCmd9; phase_o = sdspi_pkg::PhLead;
      res_o.tx_byte = 8'hFF; res_o.tx_valid = 1'b1;
    end else begin
      res_o.tx_byte = 8'hFF; res_o.tx_valid = 1'b1;
      case (phase_i)
        sdspi_pkg::PhDummy: begin
          bcnt_o = bcnt_i - 10'd1;
          if (bcnt_o != '0) begin
          end else if (seq_i == sdspi_pkg::StClk10) begin
            cmd_o = sdspi_pkg::Cmd0; arg_o = '0; seq_o = sdspi_pkg::StCmd0;
            phase_o = sdspi_pkg::PhLead;
          end else begin
            att_o = '0; v2_o = 1'b1; cmd_o = sdspi_pkg::Cmd8; arg_o = 32'h1AA;
            seq_o = sdspi_pkg::StCmd8; phase_o = sdspi_pkg::PhLead;
          end
        end
        sdspi_pkg::PhLead: begin
          bcnt_o = 10'd1; phase_o = sdspi_pkg::PhFrame;
          res_o.tx_byte = {2'b01, cmd_i}; res_o.chip_select = 1'b1;
        end
        sdspi_pkg::PhFrame: begin
          res_o.chip_select = 1'b1;
          if (bcnt_i < 10'd6) begin
            res_o.tx_byte = fbyte; bcnt_o = bcnt_inc;
          end else begin
            pcnt_o = '0; phase_o = sdspi_pkg::PhPoll;
          end
        end
        sdspi_pkg::PhPoll: begin
          pcnt_o = pcnt_inc;
          if (rx != 8'hFF || pcnt_inc >= 17'd256) begin
            resp_o = rx;
            if (rx == 8'h00 && cmd_i == sdspi_pkg::Cmd58) begin
              bcnt_o = '0; phase_o = sdspi_pkg::PhOcr; res_o.chip_select = 1'b1;
            end else begin
              phase_o = sdspi_pkg::PhTail;
            end
          end else res_o.chip_select = 1'b1;
        end
        sdspi_pkg::PhOcr: begin
          if (bcnt_i == '0) hc_o = rx[6];
          bcnt_o = bcnt_inc;
          if (bcnt_inc < 10'd4) res_o.chip_select = 1'b1;
          else phase_o = sdspi_pkg::PhTail;
        end
        sdspi_pkg::PhTail: begin
          case (seq_i)
            sdspi_pkg::StCmd0: begin
              att_o = att_inc;
              if (att_inc > 8'hFE) begin
                res_o.tx_byte = '0; res_o.tx_valid = 1'b0;
                res_o.done_res = 1'b1; res_o.status = sdspi_pkg::StatTimeout;
                phase_o = sdspi_pkg::PhIdle;
              end else begin
                bcnt_o = (resp_i != 8'h01) ? 10'd10 : 10'd2;
                seq_o = (resp_i != 8'h01) ? sdspi_pkg::StClk10 : sdspi_pkg::StClk2;
                phase_o = sdspi_pkg::PhDummy;
              end
            end
            sdspi_pkg::StCmd8: begin
              att_o = att_inc; phase_o = sdspi_pkg::PhLead;
              if (att_inc <= 8'hF0 && resp_i != 8'h01) begin
                cmd_o = sdspi_pkg::Cmd8; arg_o = 32'h1AA; seq_o = sdspi_pkg::StCmd8;
              end else begin
                if (att_inc > 8'hF0) begin
                  v2_o = 1'b0; type_o = sdspi_pkg::TypeV1;
                end
                att_o = '0; cmd_o = sdspi_pkg::Cmd55; arg_o = '0;
                seq_o = sdspi_pkg::StCmd55;
              end
            end
            sdspi_pkg::StCmd55: begin
              cmd_o = sdspi_pkg::Cmd41; arg_o = 32'h4000_0000; seq_o = sdspi_pkg::StCmd41;
              phase_o = sdspi_pkg::PhLead;
            end
            sdspi_pkg::StCmd41: begin
              att_o = att_inc; phase_o = sdspi_pkg::PhLead;
              if (att_inc > 8'hF0) begin
                res_o.tx_byte = '0; res_o.tx_valid = 1'b0;
                res_o.done_res = 1'b1; res_o.status = sdspi_pkg::StatTimeout;
                phase_o = sdspi_pkg::PhIdle;
              end else if (resp_i != 8'h00) begin
                cmd_o = sdspi_pkg::Cmd55; arg_o = '0; seq_o = sdspi_pkg::StCmd55;
              end else begin
                att_o = '0; hc_o = 1'b0;
                if (v2_i) begin
                  cmd_o = sdspi_pkg::Cmd58; arg_o = '0; seq_o = sdspi_pkg::StCmd58;
                end else begin
                  speed_o = 1'b1; cmd_o = sdspi_pkg::Cmd59; arg_o = '0;
                  seq_o = sdspi_pkg::StCmd59;
                end
              end
            end
            sdspi_pkg::StCmd58: begin
              att_o = att_inc; phase_o = sdspi_pkg::PhLead; arg_o = '0;
              if (att_inc > 8'hFE || resp_i == 8'h00) begin
                type_o = hc_i ? sdspi_pkg::TypeHc : sdspi_pkg::TypeStd2;
                speed_o = 1'b1; cmd_o = sdspi_pkg::Cmd59; seq_o = sdspi_pkg::StCmd59;
              end else begin
                cmd_o = sdspi_pkg::Cmd58; seq_o = sdspi_pkg::StCmd58;
              end
            end
            sdspi_pkg::StCmd59: begin
              cmd_o = sdspi_pkg::Cmd16; arg_o = 32'(sdspi_pkg::SectorBytes);
              seq_o = sdspi_pkg::StCmd16; phase_o = sdspi_pkg::PhLead;
            end
            sdspi_pkg::StCmd16: begin
              res_o.tx_byte = '0; res_o.tx_valid = 1'b0;
              res_o.done_res = 1'b1; phase_o = sdspi_pkg::PhIdle;
            end
            default: begin
              if (resp_i != 8'h00) begin
                res_o.tx_byte = '0; res_o.tx_valid = 1'b0;
                res_o.done_res = 1'b1; res_o.status = sdspi_pkg::StatReject;
                phase_o = sdspi_pkg::PhIdle;
              end else begin
                pcnt_o = '0; phase_o = sdspi_pkg::PhToken; res_o.chip_select = 1'b1;
              end
            end
          endcase
        end
        sdspi_pkg::PhToken: begin
          pcnt_o = pcnt_inc;
          if (rx == 8'hFE) begin
            bcnt_o = '0; phase_o = sdspi_pkg::PhData; res_o.chip_select = 1'b1;
          end else if (pcnt_inc >= 17'h10000) begin
            res_o.tx_byte = '0; res_o.tx_valid = 1'b0;
            res_o.done_res = 1'b1; res_o.status = sdspi_pkg::StatTimeout;
            phase_o = sdspi_pkg::PhIdle;
          end else res_o.chip_select = 1'b1;
        end
        sdspi_pkg::PhData: begin
          res_o.chip_select = 1'b1;
          if (op_i == sdspi_pkg::ActRead) begin
            res_o.data_byte = rx; res_o.data_valid = 1'b1;
            res_o.data_last = (bcnt_i == 10'(sdspi_pkg::SectorBytes - 1));
          end else if (bcnt_i < 10'(sdspi_pkg::CsdBytes)) begin
            csd_we_o = 1'b1;
          end
          bcnt_o = bcnt_inc;
          if (bcnt_inc >= ((op_i == sdspi_pkg::ActRead) ? 10'(sdspi_pkg::SectorBytes)
                                                         : 10'(sdspi_pkg::CsdBytes))) begin
            bcnt_o = '0; phase_o = sdspi_pkg::PhCrc;
          end
        end
        sdspi_pkg::PhCrc: begin
          bcnt_o = bcnt_inc;
          if (bcnt_inc < ((op_i == sdspi_pkg::ActRead) ? 10'd2 : 10'd3)) begin
            res_o.chip_select = 1'b1;
          end else phase_o = sdspi_pkg::PhStall;
        end
        sdspi_pkg::PhStall: begin
          res_o.tx_byte = '0; res_o.tx_valid = 1'b0;
          res_o.done_res = 1'b1; phase_o = sdspi_pkg::PhIdle;
          if (op_i == sdspi_pkg::ActCap) begin
            res_o.capacity = sdspi_pkg::csd_cap(csize_i, mult_i, bl_i);
          end
        end
        default: begin
          res_o.tx_byte = '0; res_o.tx_valid = 1'b0;
        end
      endcase
    end
    res_o.fast_clock = speed_o;
    res_o.response   = resp_o;
    res_o.card_type  = type_o;
  end

endmodule

@@ rtl/sd_card_spi_host_engine.sv @@
// Top level: SD card SPI-mode host engine with state and result registers.
// One item is accepted per cycle whenever the result register is free or being
// drained; each accepted item yields exactly one result in the result register. Only
// the CSD fields needed for the capacity are kept. A single combinational
// sequencer step lies between the input port and the state and result registers.
module sd_card_spi_host_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // action[1:0], sector[33:2], rx_byte[41:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // tx_byte, tx_valid, chip_select, fast_clock,
                                     // data_byte, data_valid, done_res, status,
                                     // response, card_type, capacity
  output logic        m_axis_tlast   // data_last
);

  sdspi_pkg::in_item_t  item;
  sdspi_pkg::out_item_t res;
  logic [3:0] phase_q, phase_d, seq_q, seq_d;
  logic [1:0] op_q, op_d, type_q, type_d;
  logic [5:0] cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic [9:0] bcnt_q, bcnt_d;
  logic [16:0] pcnt_q, pcnt_d;
  logic [7:0] att_q, att_d, resp_q, resp_d;
  logic hc_q, hc_d, v2_q, v2_d, speed_q, speed_d;
  logic csd_we;
  logic [3:0] csd_addr;
  logic [11:0] csize_q;
  logic [2:0] mult_q;
  logic [3:0] bl_q;
  logic       rvalid_q;
  logic [71:0] rdata_q;
  logic        rlast_q;
  logic        acc;

  assign item.action  = s_axis_tdata[1:0];
  assign item.sector  = s_axis_tdata[33:2];
  assign item.rx_byte = s_axis_tdata[41:34];
  assign s_axis_tready = !rvalid_q || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  sdspi_core u_core (
    .item_i(item), .phase_i(phase_q), .op_i(op_q), .cmd_i(cmd_q), .arg_i(arg_q),
    .bcnt_i(bcnt_q), .pcnt_i(pcnt_q), .att_i(att_q), .hc_i(hc_q), .v2_i(v2_q),
    .type_i(type_q), .speed_i(speed_q), .seq_i(seq_q), .resp_i(resp_q),
    .csize_i(csize_q), .mult_i(mult_q), .bl_i(bl_q),
    .phase_o(phase_d), .op_o(op_d), .cmd_o(cmd_d), .arg_o(arg_d), .bcnt_o(bcnt_d),
    .pcnt_o(pcnt_d), .att_o(att_d), .hc_o(hc_d), .v2_o(v2_d), .type_o(type_d),
    .speed_o(speed_d), .seq_o(seq_d), .resp_o(resp_d), .csd_we_o(csd_we),
    .csd_addr_o(csd_addr), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdspi_pkg::PhIdle; seq_q <= '0; op_q <= '0; type_q <= '0;
      cmd_q <= '0; arg_q <= '0; bcnt_q <= '0; pcnt_q <= '0; att_q <= '0;
      resp_q <= '0; hc_q <= 1'b0; v2_q <= 1'b0; speed_q <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      if (acc) begin
        phase_q <= phase_d; seq_q <= seq_d; op_q <= op_d; type_q <= type_d;
        cmd_q <= cmd_d; arg_q <= arg_d; bcnt_q <= bcnt_d; pcnt_q <= pcnt_d;
        att_q <= att_d; resp_q <= resp_d; hc_q <= hc_d; v2_q <= v2_d;
        speed_q <= speed_d;
      end
      if (acc) rvalid_q <= 1'b1;
      else if (m_axis_tready) rvalid_q <= 1'b0;
    end
  end

  // CSD field capture and result payload
  always_ff @(posedge clk_i) begin
    if (acc && csd_we) begin
      case (csd_addr)
        4'd5:  bl_q <= item.rx_byte[3:0];
        4'd6:  csize_q[11:10] <= item.rx_byte[1:0];
        4'd7:  csize_q[9:2] <= item.rx_byte;
        4'd8:  csize_q[1:0] <= item.rx_byte[7:6];
        4'd9:  mult_q[2:1] <= item.rx_byte[1:0];
        4'd10: mult_q[0] <= item.rx_byte[7];
        default: ;
      endcase
    end
    if (acc) begin
      rlast_q <= res.data_last;
      rdata_q <= {7'd0, res.capacity, res.card_type, res.response, res.status,
                  res.done_res, res.data_valid, res.data_byte, res.fast_clock,
                  res.chip_select, res.tx_valid, res.tx_byte};
    end
  end

  assign m_axis_tvalid = rvalid_q;
  assign m_axis_tdata  = rdata_q;
  assign m_axis_tlast  = rlast_q;

endmodule

@@ bench/tb_sd_card_spi_host_engine.sv @@
// Testbench for the SD card SPI host engine: card-model stimulus, scoreboard check.
`timescale 1ns / 1ps

module tb_sd_card_spi_host_engine;

  class SdCardScoreboard;
    logic [3:0]  phase, stage;
    logic [1:0]  op;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [9:0]  bcnt;
    logic [16:0] pcnt;
    logic [7:0]  tries, resp;
    logic        hc, v2, fast;
    logic [1:0]  ctype;
    logic [7:0]  csd [16];
    sdspi_pkg::out_item_t o;
    sdspi_pkg::out_item_t expect_q[$];
    int          errors, checked, sectors, caps, inits;

    function new();
      phase = sdspi_pkg::PhIdle; stage = sdspi_pkg::StClk10; op = '0; cmd = '0;
      arg = 0; bcnt = 0; pcnt = 0;
      tries = 0; resp = 0; hc = 0; v2 = 0; fast = 0; ctype = sdspi_pkg::TypeUnknown;
      errors = 0; checked = 0; sectors = 0; caps = 0; inits = 0;
    endfunction

    function void emit(logic [7:0] b, logic cs);
      o.tx_byte = b; o.tx_valid = 1'b1; o.chip_select = cs;
    endfunction

    function void end_op(logic [1:0] st, logic [31:0] cap);
      o.done_res = 1'b1; o.status = st; o.capacity = cap; phase = sdspi_pkg::PhIdle;
      if (st == sdspi_pkg::StatOk && op == sdspi_pkg::ActRead) sectors++;
      if (st == sdspi_pkg::StatOk && op == sdspi_pkg::ActCap) caps++;
      if (st == sdspi_pkg::StatOk && op == sdspi_pkg::ActInit) inits++;
    endfunction

    function void send_cmd(logic [5:0] c, logic [31:0] a, logic [3:0] nx);
      cmd = c; arg = a; stage = nx; phase = sdspi_pkg::PhLead; emit(8'hFF, 1'b0);
    endfunction

    function void send_dummy(logic [9:0] n, logic [3:0] nx);
      bcnt = n; stage = nx; phase = sdspi_pkg::PhDummy; emit(8'hFF, 1'b0);
    endfunction

    function logic [7:0] frame_byte(logic [9:0] k);
      if (k == 0) return {2'b01, cmd};
      if (k <= 4) return 8'(arg >> (8 * (4 - k)));
      return (cmd == sdspi_pkg::Cmd8) ? 8'h87 : 8'h95;
    endfunction

    function void start_acmd();
      tries = 0; send_cmd(sdspi_pkg::Cmd55, 32'd0, sdspi_pkg::StCmd55);
    endfunction

    function void init_tail();
      fast = 1'b1; send_cmd(sdspi_pkg::Cmd59, 32'd0, sdspi_pkg::StCmd59);
    endfunction

    function logic [31:0] csd_capacity();
      logic [11:0] csize;
      logic [2:0]  mult;
      logic [4:0]  sh;
      logic [63:0] wide;
      csize = {csd[6][1:0], csd[7], csd[8][7:6]};
      mult  = {csd[9][1:0], csd[10][7]};
      sh    = 5'(mult) + 5'd2 + 5'(csd[5][3:0]);
      wide  = (64'(csize) + 64'd1) << sh;
      return wide[31:0];
    endfunction

    function void command_done(logic [7:0] r1);
      case (stage)
        sdspi_pkg::StCmd0: begin
          tries++;
          if (tries > 8'hFE) end_op(sdspi_pkg::StatTimeout, 0);
          else if (r1 != 8'h01) send_dummy(10'd10, sdspi_pkg::StClk10);
          else send_dummy(10'd2, sdspi_pkg::StClk2);
        end
        sdspi_pkg::StCmd8: begin
          tries++;
          if (tries > 8'hF0) begin
            v2 = 0; ctype = sdspi_pkg::TypeV1; start_acmd();
          end else if (r1 != 8'h01) send_cmd(sdspi_pkg::Cmd8, 32'h1AA, sdspi_pkg::StCmd8);
          else start_acmd();
        end
        sdspi_pkg::StCmd55: send_cmd(sdspi_pkg::Cmd41, 32'h4000_0000, sdspi_pkg::StCmd41);
        sdspi_pkg::StCmd41: begin
          tries++;
          if (tries > 8'hF0) end_op(sdspi_pkg::StatTimeout, 0);
          else if (r1 != 8'h00) send_cmd(sdspi_pkg::Cmd55, 32'd0, sdspi_pkg::StCmd55);
          else begin
            tries = 0; hc = 0;
            if (v2) send_cmd(sdspi_pkg::Cmd58, 32'd0, sdspi_pkg::StCmd58);
            else init_tail();
          end
        end
        sdspi_pkg::StCmd58: begin
          tries++;
          if (tries > 8'hFE || r1 == 8'h00) begin
            ctype = hc ? sdspi_pkg::TypeHc : sdspi_pkg::TypeStd2; init_tail();
          end else send_cmd(sdspi_pkg::Cmd58, 32'd0, sdspi_pkg::StCmd58);
        end
        sdspi_pkg::StCmd59: send_cmd(sdspi_pkg::Cmd16, 32'd512, sdspi_pkg::StCmd16);
        sdspi_pkg::StCmd16: end_op(sdspi_pkg::StatOk, 0);
        default: begin
          if (r1 != 8'h00) end_op(sdspi_pkg::StatReject, 0);
          else begin
            pcnt = 0; phase = sdspi_pkg::PhToken; emit(8'hFF, 1'b1);
          end
        end
      endcase
    endfunction

    function void take_byte(logic [7:0] rx);
      case (phase)
        sdspi_pkg::PhDummy: begin
          bcnt--;
          if (bcnt != 0) emit(8'hFF, 1'b0);
          else if (stage == sdspi_pkg::StClk10) begin
            send_cmd(sdspi_pkg::Cmd0, 32'd0, sdspi_pkg::StCmd0);
          end else begin
            tries = 0; v2 = 1; send_cmd(sdspi_pkg::Cmd8, 32'h1AA, sdspi_pkg::StCmd8);
          end
        end
        sdspi_pkg::PhLead: begin
          bcnt = 1; phase = sdspi_pkg::PhFrame; emit(frame_byte(0), 1'b1);
        end
        sdspi_pkg::PhFrame: begin
          if (bcnt < 6) begin
            emit(frame_byte(bcnt), 1'b1); bcnt++;
          end else begin
            pcnt = 0; phase = sdspi_pkg::PhPoll; emit(8'hFF, 1'b1);
          end
        end
        sdspi_pkg::PhPoll: begin
          pcnt++;
          if (rx != 8'hFF || pcnt >= 256) begin
            resp = rx;
            if (rx == 8'h00 && cmd == sdspi_pkg::Cmd58) begin
              bcnt = 0; phase = sdspi_pkg::PhOcr; emit(8'hFF, 1'b1);
            end else begin
              phase = sdspi_pkg::PhTail; emit(8'hFF, 1'b0);
            end
          end else emit(8'hFF, 1'b1);
        end
        sdspi_pkg::PhOcr: begin
          if (bcnt == 0) hc = rx[6];
          bcnt++;
          if (bcnt < 4) emit(8'hFF, 1'b1);
          else begin
            phase = sdspi_pkg::PhTail; emit(8'hFF, 1'b0);
          end
        end
        sdspi_pkg::PhTail: command_done(resp);
        sdspi_pkg::PhToken: begin
          pcnt++;
          if (rx == 8'hFE) begin
            bcnt = 0; phase = sdspi_pkg::PhData; emit(8'hFF, 1'b1);
          end else if (pcnt >= 17'd65536) end_op(sdspi_pkg::StatTimeout, 0);
          else emit(8'hFF, 1'b1);
        end
        sdspi_pkg::PhData: begin
          if (op == sdspi_pkg::ActRead) begin
            o.data_byte = rx; o.data_valid = 1'b1; o.data_last = (bcnt == 10'd511);
          end else if (bcnt < 16) csd[bcnt[3:0]] = rx;
          bcnt++;
          if (bcnt >= ((op == sdspi_pkg::ActRead) ? 10'd512 : 10'd16)) begin
            bcnt = 0; phase = sdspi_pkg::PhCrc;
          end
          emit(8'hFF, 1'b1);
        end
        sdspi_pkg::PhCrc: begin
          bcnt++;
          if (bcnt < ((op == sdspi_pkg::ActRead) ? 10'd2 : 10'd3)) emit(8'hFF, 1'b1);
          else begin
            phase = sdspi_pkg::PhStall; emit(8'hFF, 1'b0);
          end
        end
        sdspi_pkg::PhStall: begin
          end_op(sdspi_pkg::StatOk, (op == sdspi_pkg::ActCap) ? csd_capacity() : 32'd0);
        end
        default: ;
      endcase
    endfunction

    function void note_input(sdspi_pkg::in_item_t it);
      o = '0;
      case (it.action)
        sdspi_pkg::ActInit: begin
          op = sdspi_pkg::ActInit; fast = 0; tries = 0;
          send_dummy(10'd10, sdspi_pkg::StClk10);
        end
        sdspi_pkg::ActRead: begin
          op = sdspi_pkg::ActRead;
          send_cmd(sdspi_pkg::Cmd17, hc ? it.sector : {it.sector[22:0], 9'd0},
                   sdspi_pkg::StCmd17);
        end
        sdspi_pkg::ActCap: begin
          op = sdspi_pkg::ActCap; send_cmd(sdspi_pkg::Cmd9, 32'd0, sdspi_pkg::StCmd9);
        end
        default: if (phase != sdspi_pkg::PhIdle) take_byte(it.rx_byte);
      endcase
      o.fast_clock = fast; o.response = resp; o.card_type = ctype;
      expect_q.push_back(o);
    endfunction

    function void check_result(sdspi_pkg::out_item_t got);
      sdspi_pkg::out_item_t e;
      checked++;
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      e = expect_q.pop_front();
      if (got.tx_byte !== e.tx_byte || got.tx_valid !== e.tx_valid ||
          got.chip_select !== e.chip_select || got.fast_clock !== e.fast_clock ||
          got.data_byte !== e.data_byte || got.data_valid !== e.data_valid ||
          got.data_last !== e.data_last || got.done_res !== e.done_res ||
          got.status !== e.status || got.response !== e.response ||
          got.card_type !== e.card_type || got.capacity !== e.capacity) begin
        errors++;
        if (errors <= 10) $display("ERROR: result %0d\n  exp %p\n  got %p", checked, e, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  SdCardScoreboard sb = new();
  int  items = 0;
  int  cycles = 0;
  bit  send_burst = 0;
  bit  recv_burst = 0;
  bit  ocr_hc = 0;
  bit  bad_csd = 0;

  always #5 clk_i = ~clk_i;

  sd_card_spi_host_engine dut (.*);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: check on handshake, then stall a random number of cycles
  initial begin
    sdspi_pkg::out_item_t got;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.tx_byte     = m_axis_tdata[7:0];
        got.tx_valid    = m_axis_tdata[8];
        got.chip_select = m_axis_tdata[9];
        got.fast_clock  = m_axis_tdata[10];
        got.data_byte   = m_axis_tdata[18:11];
        got.data_valid  = m_axis_tdata[19];
        got.done_res    = m_axis_tdata[20];
        got.status      = m_axis_tdata[22:21];
        got.response    = m_axis_tdata[30:23];
        got.card_type   = m_axis_tdata[32:31];
        got.capacity    = m_axis_tdata[64:33];
        got.data_last   = m_axis_tlast;
        sb.check_result(got);
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        stall = recv_burst ? 0 : $urandom_range(0, 10);
      end
      if (!rst_ni) m_axis_tready <= 1'b0;
      else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(logic [1:0] action, logic [31:0] sector, logic [7:0] rx);
    sdspi_pkg::in_item_t it;
    int gap;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.action = action; it.sector = sector; it.rx_byte = rx;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, rx, sector, action};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(it);
    items++;
  endtask

  // emulated card answer for the transfer the engine just asked for
  function automatic logic [7:0] card_answer();
    int r;
    r = $urandom_range(0, 9);
    case (sb.phase)
      sdspi_pkg::PhPoll: begin
        if (r < 2) return 8'hFF;
        if (r == 2) return 8'($urandom);
        case (sb.cmd)
          sdspi_pkg::Cmd0, sdspi_pkg::Cmd55, sdspi_pkg::Cmd8: return 8'h01;
          sdspi_pkg::Cmd41: return (r < 5) ? 8'h01 : 8'h00;
          default: return 8'h00;
        endcase
      end
      sdspi_pkg::PhOcr: return ocr_hc ? (8'($urandom) | 8'h40) : 8'($urandom);
      sdspi_pkg::PhToken: return (r < 7) ? 8'hFE : ((r == 7) ? 8'($urandom) : 8'hFF);
      sdspi_pkg::PhData: return bad_csd ? ((r < 5) ? 8'hFF : 8'h00) : 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_op(logic [1:0] action, logic [31:0] sector, int max_bytes);
    int n;
    n = 0;
    send_item(action, sector, 8'($urandom));
    while (sb.phase != sdspi_pkg::PhIdle && n < max_bytes) begin
      send_item(sdspi_pkg::ActByte, 32'($urandom), card_answer());
      n++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  initial begin
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(sdspi_pkg::ActByte, 32'hFFFF_FFFF, 8'hFF);
    send_item(sdspi_pkg::ActByte, 32'h0, 8'h00);
    ocr_hc = 1;
    run_op(sdspi_pkg::ActInit, 0, 100000);
    run_op(sdspi_pkg::ActRead, 32'hFFFF_FFFF, 30);
    ocr_hc = 0;
    run_op(sdspi_pkg::ActInit, 0, 100000);
    run_op(sdspi_pkg::ActRead, 32'hFFFF_FFFF, 100000);
    bad_csd = 1;
    run_op(sdspi_pkg::ActCap, 0, 100000);
    bad_csd = 0;
    drain();

    // random
    while (items < 850) begin
      r = $urandom_range(0, 99);
      ocr_hc = $urandom_range(0, 1);
      bad_csd = ($urandom_range(0, 7) == 0);
      if (r < 10) send_item(sdspi_pkg::ActByte, 32'($urandom), 8'($urandom));
      else if (r < 40) begin
        run_op(sdspi_pkg::ActInit, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                                    : 100000);
      end else if (r < 55) begin
        run_op(sdspi_pkg::ActRead, 32'($urandom), $urandom_range(1, 60));
      end else begin
        run_op(sdspi_pkg::ActCap, 0, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                                                   : 100000);
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items, checked %0d results.", items, sb.checked);
    $display("Completed %0d inits, %0d sector reads, %0d capacity reads.",
             sb.inits, sb.sectors, sb.caps);
    if (sb.errors == 0 && sb.expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sd_card_spi_host_engine.f @@
rtl/sdspi_pkg.sv
rtl/sdspi_core.sv
rtl/sd_card_spi_host_engine.sv
bench/tb_sd_card_spi_host_engine.sv
